/* rtl/sip_pkg.sv */
// Shared types and constants for the segment intersection pipeline.
// Used by sip_front, sip_div and segment_intersection_point; no dependencies.
`default_nettype none
package sip_pkg;
    localparam int MARGIN_WIDTH = 15;
    localparam int MARGIN_SHIFT = 16;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_ctrl;
endpackage
`default_nettype wire

/* rtl/segment_intersection_point.sv */
// Throughput: one transfer per cycle; the pipeline advances whenever the output is free.
// The latency is six front stages, one divider stage per quotient bit and the output register.
// Reset is synchronous and active low; it clears the valid bits and sets r_margin to 0.
// Depends on sip_pkg, sip_front and sip_div.
`default_nettype none
module segment_intersection_point #(
    parameter int COORD_WIDTH = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [sip_pkg::MARGIN_WIDTH-1:0]     i_cfg_wdata,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  signed [COORD_WIDTH-1:0]        i_ax,
    input  wire  signed [COORD_WIDTH-1:0]        i_ay,
    input  wire  signed [COORD_WIDTH-1:0]        i_bx,
    input  wire  signed [COORD_WIDTH-1:0]        i_by_coord,
    input  wire  signed [COORD_WIDTH-1:0]        i_cx,
    input  wire  signed [COORD_WIDTH-1:0]        i_cy,
    input  wire  signed [COORD_WIDTH-1:0]        i_dx,
    input  wire  signed [COORD_WIDTH-1:0]        i_dy,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic                                 o_hit,
    output logic signed [COORD_WIDTH-1:0]        o_px,
    output logic signed [COORD_WIDTH-1:0]        o_py
);
    import sip_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 2;
    localparam int NW = 3 * W + 1;

    logic [MARGIN_WIDTH-1:0] r_margin;
    logic en;
    t_ctrl front_ctrl;
    t_ctrl r_ctrl [W];
    logic [NW-1:0] numx, numy;
    logic [DW-2:0] den;
    logic signed [W-1:0] fax, fay, dax, day;
    logic fnegx, fnegy, dnegx, dnegy;
    logic [W-1:0] qx, qy;
    logic signed [W-1:0] n_px, n_py;

    assign en = !o_valid || !i_stall;
    assign o_stall = !en || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    sip_front #(.W(W), .DW(DW), .NW(NW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_margin(r_margin),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy), .i_dx(i_dx), .i_dy(i_dy),
        .o_ctrl(front_ctrl), .o_numx(numx), .o_numy(numy), .o_den(den),
        .o_ax(fax), .o_ay(fay), .o_negx(fnegx), .o_negy(fnegy)
    );

    sip_div #(.W(W), .DW(DW), .NW(NW)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(numx), .i_den(den), .i_a(fax),
        .i_neg(fnegx), .o_q(qx), .o_a(dax), .o_neg(dnegx)
    );

    sip_div #(.W(W), .DW(DW), .NW(NW)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(numy), .i_den(den), .i_a(fay),
        .i_neg(fnegy), .o_q(qy), .o_a(day), .o_neg(dnegy)
    );

    for (genvar s = 0; s < W; s++) begin : g_ctrl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[s] <= '0;
            end else if (en) begin
                r_ctrl[s] <= (s == 0) ? front_ctrl : r_ctrl[(s == 0) ? 0 : s - 1];
            end
        end
    end

    function automatic logic signed [W-1:0] sat_point(input logic signed [W-1:0] a,
                                                     input logic [W-1:0] q,
                                                     input logic neg);
        logic signed [W+1:0] sum;
        sum = neg ? ({{2{a[W-1]}}, a} - {2'b00, q}) : ({{2{a[W-1]}}, a} + {2'b00, q});
        if (sum[W+1:W-1] == '0 || sum[W+1:W-1] == '1) begin
            sat_point = sum[W-1:0];
        end else if (sum[W+1]) begin
            sat_point = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_point = {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    always_comb begin
        n_px = r_ctrl[W-1].hit ? sat_point(dax, qx, dnegx) : '0;
        n_py = r_ctrl[W-1].hit ? sat_point(day, qy, dnegy) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_ctrl[W-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit <= r_ctrl[W-1].hit;
            o_px <= n_px;
            o_py <= n_py;
        end
    end

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_px == '0 && o_py == '0))
        else $error("point not zero on a miss");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_ctrl[W-1]))
        else $error("divider tail moved while stalled");

    a_stall_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output");
endmodule
`default_nettype wire

/* rtl/sip_front.sv */
// Cross products, sign normalization and the margin test, in six register stages.
// Depends on sip_pkg; feeds the numerator and denominator to the sip_div dividers.
`default_nettype none
module sip_front #(
    parameter int W  = 24,
    parameter int DW = 2 * W + 2,
    parameter int NW = 3 * W + 1
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire  [sip_pkg::MARGIN_WIDTH-1:0]     i_margin,
    input  wire  signed [W-1:0]                  i_ax,
    input  wire  signed [W-1:0]                  i_ay,
    input  wire  signed [W-1:0]                  i_bx,
    input  wire  signed [W-1:0]                  i_by,
    input  wire  signed [W-1:0]                  i_cx,
    input  wire  signed [W-1:0]                  i_cy,
    input  wire  signed [W-1:0]                  i_dx,
    input  wire  signed [W-1:0]                  i_dy,
    output sip_pkg::t_ctrl                       o_ctrl,
    output logic [NW-1:0]                        o_numx,
    output logic [NW-1:0]                        o_numy,
    output logic [DW-2:0]                        o_den,
    output logic signed [W-1:0]                  o_ax,
    output logic signed [W-1:0]                  o_ay,
    output logic                                 o_negx,
    output logic                                 o_negy
);
    import sip_pkg::*;

    localparam int XW = DW + MARGIN_SHIFT + 1;

    logic [5:0] r_v;

    logic signed [W:0] r1_abx, r1_aby, r1_cdx, r1_cdy, r1_acx, r1_acy;
    logic signed [W-1:0] r1_ax, r1_ay;

    logic signed [DW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [W:0] r2_abx, r2_aby;
    logic signed [W-1:0] r2_ax, r2_ay;

    logic signed [DW-1:0] r3_den, r3_tn, r3_un;
    logic signed [W:0] r3_abx, r3_aby;
    logic signed [W-1:0] r3_ax, r3_ay;

    logic signed [DW-1:0] r4_den, r4_tn, r4_un;
    logic r4_zero;
    logic signed [W:0] r4_abx, r4_aby;
    logic signed [W-1:0] r4_ax, r4_ay;

    logic signed [XW-1:0] r5_dm;
    logic signed [DW-1:0] r5_den, r5_tn, r5_un;
    logic r5_zero;
    logic [2*W:0] r5_plx, r5_ply;
    logic [2*W-1:0] r5_phx, r5_phy;
    logic r5_negx, r5_negy;
    logic signed [W-1:0] r5_ax, r5_ay;

    logic r6_hit;

    logic [W-1:0] n_magx, n_magy;
    logic signed [W:0] n_absx, n_absy;
    logic signed [XW-1:0] n_lhs_t, n_lhs_u, n_hi;
    logic n_in_t, n_in_u;

    always_comb begin
        n_absx = r4_abx[W] ? -r4_abx : r4_abx;
        n_absy = r4_aby[W] ? -r4_aby : r4_aby;
        n_magx = n_absx[W-1:0];
        n_magy = n_absy[W-1:0];
        n_lhs_t = XW'(r5_tn) <<< MARGIN_SHIFT;
        n_lhs_u = XW'(r5_un) <<< MARGIN_SHIFT;
        n_hi = (XW'(r5_den) <<< MARGIN_SHIFT) - r5_dm;
        n_in_t = (r5_dm < n_lhs_t) && (n_lhs_t < n_hi);
        n_in_u = (r5_dm < n_lhs_u) && (n_lhs_u < n_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_abx <= {i_bx[W-1], i_bx} - {i_ax[W-1], i_ax};
            r1_aby <= {i_by[W-1], i_by} - {i_ay[W-1], i_ay};
            r1_cdx <= {i_dx[W-1], i_dx} - {i_cx[W-1], i_cx};
            r1_cdy <= {i_dy[W-1], i_dy} - {i_cy[W-1], i_cy};
            r1_acx <= {i_cx[W-1], i_cx} - {i_ax[W-1], i_ax};
            r1_acy <= {i_cy[W-1], i_cy} - {i_ay[W-1], i_ay};
            r1_ax <= i_ax;
            r1_ay <= i_ay;

            r2_p0 <= r1_abx * r1_cdy;
            r2_p1 <= r1_aby * r1_cdx;
            r2_p2 <= r1_acx * r1_cdy;
            r2_p3 <= r1_acy * r1_cdx;
            r2_p4 <= r1_acx * r1_aby;
            r2_p5 <= r1_acy * r1_abx;
            r2_abx <= r1_abx;
            r2_aby <= r1_aby;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;

            r3_den <= r2_p0 - r2_p1;
            r3_tn <= r2_p2 - r2_p3;
            r3_un <= r2_p4 - r2_p5;
            r3_abx <= r2_abx;
            r3_aby <= r2_aby;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;

            r4_zero <= (r3_den == '0);
            r4_den <= r3_den[DW-1] ? -r3_den : r3_den;
            r4_tn <= r3_den[DW-1] ? -r3_tn : r3_tn;
            r4_un <= r3_den[DW-1] ? -r3_un : r3_un;
            r4_abx <= r3_abx;
            r4_aby <= r3_aby;
            r4_ax <= r3_ax;
            r4_ay <= r3_ay;

            r5_dm <= r4_den * $signed({1'b0, i_margin});
            r5_den <= r4_den;
            r5_tn <= r4_tn;
            r5_un <= r4_un;
            r5_zero <= r4_zero;
            r5_plx <= r4_tn[W:0] * n_magx;
            r5_ply <= r4_tn[W:0] * n_magy;
            r5_phx <= r4_tn[2*W:W+1] * n_magx;
            r5_phy <= r4_tn[2*W:W+1] * n_magy;
            r5_negx <= r4_abx[W];
            r5_negy <= r4_aby[W];
            r5_ax <= r4_ax;
            r5_ay <= r4_ay;

            r6_hit <= !r5_zero && n_in_t && n_in_u;
            o_numx <= NW'(r5_plx) + {r5_phx, {(W+1){1'b0}}};
            o_numy <= NW'(r5_ply) + {r5_phy, {(W+1){1'b0}}};
            o_den <= r5_den[DW-2:0];
            o_ax <= r5_ax;
            o_ay <= r5_ay;
            o_negx <= r5_negx;
            o_negy <= r5_negy;
        end
    end

    assign o_ctrl.valid = r_v[5];
    assign o_ctrl.hit = r6_hit;
endmodule
`default_nettype wire

/* rtl/sip_div.sv */
// Restoring divider, one quotient bit per register stage, for one axis.
// Imports sip_pkg; carries the start coordinate and sign.
`default_nettype none
module sip_div #(
    parameter int W  = 24,
    parameter int DW = 2 * W + 2,
    parameter int NW = 3 * W + 1
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire  [NW-1:0]        i_num,
    input  wire  [DW-2:0]        i_den,
    input  wire  signed [W-1:0]  i_a,
    input  wire                  i_neg,
    output logic [W-1:0]         o_q,
    output logic signed [W-1:0]  o_a,
    output logic                 o_neg
);
    import sip_pkg::*;

    logic [DW-2:0] r_rem [W];
    logic [W-1:0] r_low [W];
    logic [W-1:0] r_q [W];
    logic [DW-2:0] r_den [W];
    logic signed [W-1:0] r_a [W];
    logic r_neg [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [DW-2:0] n_rem_in, n_den_in;
        logic [W-1:0] n_low_in, n_q_in;
        logic signed [W-1:0] n_a_in;
        logic n_neg_in;
        logic [DW-1:0] n_cat, n_diff;

        if (s == 0) begin : g_first
            assign n_rem_in = i_num[NW-1:W];
            assign n_low_in = i_num[W-1:0];
            assign n_q_in = '0;
            assign n_den_in = i_den;
            assign n_a_in = i_a;
            assign n_neg_in = i_neg;
        end else begin : g_next
            assign n_rem_in = r_rem[s-1];
            assign n_low_in = r_low[s-1];
            assign n_q_in = r_q[s-1];
            assign n_den_in = r_den[s-1];
            assign n_a_in = r_a[s-1];
            assign n_neg_in = r_neg[s-1];
        end

        assign n_cat = {n_rem_in, n_low_in[W-1]};
        assign n_diff = n_cat - {1'b0, n_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_diff[DW-1] ? n_cat[DW-2:0] : n_diff[DW-2:0];
                r_q[s] <= {n_q_in[W-2:0], !n_diff[DW-1]};
                r_low[s] <= {n_low_in[W-2:0], 1'b0};
                r_den[s] <= n_den_in;
                r_a[s] <= n_a_in;
                r_neg[s] <= n_neg_in;
            end
        end
    end

    assign o_q = r_q[W-1];
    assign o_a = r_a[W-1];
    assign o_neg = r_neg[W-1];
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for segment_intersection_point: directed and random segment pairs, each result
// checked against a hand-written expectation or a wide-integer crossing predictor kept in this file.
// Depends on rtl/sip_pkg.sv and rtl/segment_intersection_point.sv.
`timescale 1ns / 1ps
module testbench;
    localparam int CW = 24;
    localparam int LATENCY = CW + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT = 10;

    typedef logic signed [127:0] w_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t ax, ay, bx, by_coord, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        logic   hit;
        coord_t px, py;
    } crossing_t;

    typedef struct {
        seg_pair_t seg;
        bit        typed;
        crossing_t want;
    } stim_row_t;

    logic i_clk, i_rst_n, i_cfg_we, i_valid, i_stall;
    logic [sip_pkg::MARGIN_WIDTH-1:0] i_cfg_wdata;
    coord_t i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy;
    logic o_stall, o_valid, o_hit;
    coord_t o_px, o_py;

    segment_intersection_point #(.COORD_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy), .i_dx(i_dx), .i_dy(i_dy),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit), .o_px(o_px), .o_py(o_py)
    );

    stim_row_t    pending_q[$];
    crossing_t    crossing_q[$];
    logic [14:0]  margin_copy;
    int           mismatches;
    int           transfers_in;
    int           cycles;
    bit           hold_off;

    function automatic bit strictly_inside(w_t num, w_t den, w_t m);
        w_t one;
        one = 65536;
        return (den * m < num * one) && (num * one < den * (one - m));
    endfunction

    function automatic coord_t point_on_axis(w_t a, w_t ab, w_t tn, w_t den);
        w_t mag, q, qs, p;
        mag = (ab < 0) ? -ab : ab;
        q = (tn * mag) / den;
        qs = {82'b0, q[45:0]};
        p = (ab < 0) ? a - qs : a + qs;
        if (p > w_t'(8388607)) p = 8388607;
        if (p < w_t'(-8388608)) p = -8388608;
        return p[CW-1:0];
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s, logic [14:0] m);
        w_t ax, ay, bx, by, cx, cy, dx, dy;
        w_t abx, aby, cdx, cdy, acx, acy, den, tn, un, mw;
        crossing_t r;
        ax = s.ax; ay = s.ay; bx = s.bx; by = s.by_coord;
        cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
        mw = {113'b0, m};
        abx = bx - ax; aby = by - ay;
        cdx = dx - cx; cdy = dy - cy;
        acx = cx - ax; acy = cy - ay;
        den = abx * cdy - aby * cdx;
        tn = acx * cdy - acy * cdx;
        un = acx * aby - acy * abx;
        r.hit = 1'b0;
        r.px = '0;
        r.py = '0;
        if (den == 0) return r;
        if (den < 0) begin
            den = -den;
            tn = -tn;
            un = -un;
        end
        if (!strictly_inside(tn, den, mw) || !strictly_inside(un, den, mw)) return r;
        r.hit = 1'b1;
        r.px = point_on_axis(ax, abx, tn, den);
        r.py = point_on_axis(ay, aby, tn, den);
        return r;
    endfunction

    function automatic int span(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    function automatic stim_row_t make_row(int v[8], bit typed, bit hit, int px, int py);
        stim_row_t r;
        r.seg.ax = coord_t'(v[0]); r.seg.ay = coord_t'(v[1]);
        r.seg.bx = coord_t'(v[2]); r.seg.by_coord = coord_t'(v[3]);
        r.seg.cx = coord_t'(v[4]); r.seg.cy = coord_t'(v[5]);
        r.seg.dx = coord_t'(v[6]); r.seg.dy = coord_t'(v[7]);
        r.typed = typed;
        r.want.hit = hit;
        r.want.px = coord_t'(px);
        r.want.py = coord_t'(py);
        return r;
    endfunction

    function automatic stim_row_t random_row();
        int v[8];
        int mx, my, rx, ry, kind;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            for (int i = 0; i < 4; i++) v[i] = span(1 << 22);
            mx = (v[0] + v[2]) / 2 + span(16);
            my = (v[1] + v[3]) / 2 + span(16);
            rx = span(1 << ($urandom_range(2, 20)));
            ry = span(1 << ($urandom_range(2, 20)));
            v[4] = mx + rx; v[5] = my + ry; v[6] = mx - rx; v[7] = my - ry;
        end else if (kind < 85) begin
            for (int i = 0; i < 8; i++) v[i] = int'(coord_t'($urandom()));
        end else begin
            for (int i = 0; i < 8; i++) v[i] = span(8);
        end
        return make_row(v, 0, 0, 0, 0);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
        if (!i_rst_n) margin_copy <= '0;
        else if (i_cfg_we) margin_copy <= i_cfg_wdata;
        if (o_valid && !i_stall) begin
            if (crossing_q.size() == 0) begin
                if (mismatches < SHOW_LIMIT) $display("unexpected transfer: hit=%0d", o_hit);
                mismatches <= mismatches + 1;
            end else begin
                if (o_hit !== crossing_q[0].hit || o_px !== crossing_q[0].px
                        || o_py !== crossing_q[0].py) begin
                    if (mismatches < SHOW_LIMIT)
                        $display("mismatch: expected hit=%0d px=%0d py=%0d, got %0d %0d %0d",
                                 crossing_q[0].hit, crossing_q[0].px, crossing_q[0].py,
                                 o_hit, o_px, o_py);
                    mismatches <= mismatches + 1;
                end
                void'(crossing_q.pop_front());
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    initial begin
        int burst, gap;
        burst = $urandom_range(1, 20);
        gap = 0;
        i_valid = 1'b0;
        {i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy} = '0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (gap > 0) begin
                i_valid <= 1'b0;
                gap--;
            end else if (pending_q.size() > 0) begin
                i_ax <= pending_q[0].seg.ax; i_ay <= pending_q[0].seg.ay;
                i_bx <= pending_q[0].seg.bx; i_by_coord <= pending_q[0].seg.by_coord;
                i_cx <= pending_q[0].seg.cx; i_cy <= pending_q[0].seg.cy;
                i_dx <= pending_q[0].seg.dx; i_dy <= pending_q[0].seg.dy;
                i_valid <= 1'b1;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                if (pending_q[0].typed)
                    crossing_q.insert(crossing_q.size(), pending_q[0].want);
                else
                    crossing_q.insert(crossing_q.size(),
                                      predict_crossing(pending_q[0].seg, margin_copy));
                void'(pending_q.pop_front());
                transfers_in++;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls on a pattern that is chosen anew at random at regular intervals.
    initial begin
        int mode, n;
        n = 0;
        mode = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (n % 64 == 0) mode = $urandom_range(0, 3);
            n++;
            case (mode)
                0: i_stall <= hold_off;
                1: i_stall <= hold_off || ($urandom_range(0, 9) < 3);
                2: i_stall <= hold_off || (n % 3 == 0);
                default: i_stall <= hold_off || ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Long hold-off so that the pipeline fills and stalls its input.
    initial begin
        hold_off = 1'b0;
        wait (transfers_in >= 40);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (250) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic drain();
        wait (pending_q.size() == 0 && crossing_q.size() == 0);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_margin(logic [14:0] m);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void queue_row(stim_row_t r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    initial begin
        stim_row_t directed[$];
        logic [14:0] margins[5];
        directed = {directed, make_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0)};
        directed = {directed, make_row('{-4096, 0, 4096, 0, 0, -4096, 0, 4096}, 1, 1, 0, 0)};
        directed = {directed,
                    make_row('{-4096, 0, 4096, 0, 4096, -4096, 4096, 4096}, 1, 0, 0, 0)};
        directed = {directed, make_row('{0, 0, 4096, 0, 0, 4096, 4096, 4096}, 1, 0, 0, 0)};
        directed = {directed, make_row('{0, 0, 8192, 0, 4096, 0, 12288, 0}, 1, 0, 0, 0)};
        directed = {directed, make_row('{-4096, 0, 4096, 0, 0, 0, 0, 4096}, 1, 0, 0, 0)};
        directed = {directed, make_row('{0, 0, 4096, 4096, -4096, 0, 4096, 0}, 1, 0, 0, 0)};
        directed = {directed, make_row('{8388607, 8388607, 8388607, 8388607,
                                         8388607, 8388607, 8388607, 8388607}, 1, 0, 0, 0)};
        directed = {directed, make_row('{-8388608, -8388608, -8388608, -8388608,
                                         -8388608, -8388608, -8388608, -8388608}, 1, 0, 0, 0)};
        directed = {directed, make_row('{-8192, -8192, 0, 0, -8192, 0, 0, -8192},
                                       1, 1, -4096, -4096)};
        directed = {directed, make_row('{-8388608, -8388608, 8388607, 8388607,
                                         -8388608, 8388607, 8388607, -8388608}, 0, 0, 0, 0)};
        directed = {directed, make_row('{-8388608, 0, 8388607, 0, 0, -8388608, 0, 8388607},
                                       0, 0, 0, 0)};
        directed = {directed, make_row('{1, 1, -6, -4, -5, 3, 0, -7}, 0, 0, 0, 0)};
        directed = {directed, make_row('{0, 0, 10, 0, 3, -1, 4, 2}, 0, 0, 0, 0)};
        directed = {directed, make_row('{8388607, -8388608, -8388608, 8388607,
                                         -8388608, -8388608, 8388607, 8388607}, 0, 0, 0, 0)};
        directed = {directed, make_row('{0, 0, 3, 0, 1, -1, 1, 1}, 0, 0, 0, 0)};

        margins = '{15'd32767, 15'd1, 15'd16384, 15'($urandom()), 15'd0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) queue_row(directed[i]);
        for (int i = 0; i < 90; i++) queue_row(random_row());
        foreach (margins[p]) begin
            drain();
            write_margin(margins[p]);
            queue_row(make_row('{-4096, 0, 4096, 0, 0, -4096, 0, 4096}, 0, 0, 0, 0));
            queue_row(make_row('{0, 0, 4096, 0, 1024, -4096, 1024, 4096}, 0, 0, 0, 0));
            for (int i = 0; i < 90; i++) queue_row(random_row());
        end
        drain();
        if (mismatches == 0 && crossing_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
